### rtl/core/xcfr_pkg.sv
// Types, opcode constants and result records of the x86 control-flow resolver.
// Shared by the front decoder, the queue, the back sequencer and the checker.
`timescale 1ns / 1ps

package xcfr_pkg;

  typedef enum logic [1:0] {
    REQ_NEW = 2'd0,
    REQ_REG = 2'd1,
    REQ_MEM = 2'd2,
    REQ_ADD = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    KIND_REG_REQ = 3'd0,
    KIND_MEM_REQ = 3'd1,
    KIND_MEM_WR  = 3'd2,
    KIND_MARKER  = 3'd3,
    KIND_DONE    = 3'd4,
    KIND_NH      = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WREG = 2'd1,
    PH_WMEM = 2'd2
  } phase_e;

  localparam logic [7:0] OP_TWO_BYTE  = 8'h0F;
  localparam logic [7:0] OP_RDTSC     = 8'h31;
  localparam logic [7:0] OP_IN_RST    = 8'hE4;
  localparam logic [7:0] OP_IN_RD     = 8'hE5;
  localparam logic [7:0] OP_OUT_B     = 8'hE6;
  localparam logic [7:0] OP_OUT_D     = 8'hE7;
  localparam logic [7:0] OP_CALL      = 8'hE8;
  localparam logic [7:0] OP_JMP_NEAR  = 8'hE9;
  localparam logic [7:0] OP_JMP_SHORT = 8'hEB;
  localparam logic [7:0] OP_RET       = 8'hC3;
  localparam logic [7:0] OP_REPZ      = 8'hF3;
  localparam logic [7:0] OP_GRP5      = 8'hFF;

  localparam logic [2:0] GRP5_CALL = 3'd2;
  localparam logic [2:0] GRP5_JMP  = 3'd4;
  localparam logic [2:0] RM_SIB    = 3'd4;
  localparam logic [2:0] RM_DISP32 = 3'd5;
  localparam logic [2:0] REG_EAX   = 3'd0;

  typedef struct packed {
    req_e        req_type;
    logic [31:0] pc;
    logic [47:0] inst_bytes;
    logic [11:0] flags;
    logic [31:0] stack_ptr;
    logic [31:0] data_word;
  } in_item_t;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  reg_index;
    logic [31:0] address;
    logic [31:0] data_value;
    logic [31:0] next_pc;
    logic [31:0] next_sp;
    logic [1:0]  write_mask;
    logic [31:0] eax_value;
    logic [31:0] edx_value;
    logic [7:0]  marker_port;
    logic [31:0] marker_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic      two;
    out_item_t res_first;
    out_item_t res_last;
  } q_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

### rtl/core/x86_control_flow_resolver.sv
// Top level of the x86 control-flow resolver: front decoder, result queue and
// back sequencer. Depends on xcfr_pkg, xcfr_front, xcfr_queue and xcfr_back.
//
// Input channel (in_valid_i / in_stall_o / in_item_i) carries new instructions,
// register and memory read data, and retired-count additions. Output channel
// (out_valid_o / out_stall_i / out_item_o) carries result beats: operand
// requests, memory writes, markers, done and not-handled. Each input item gives
// zero, one or two beats; the last beat of an item has last set.
// An accepted item is written into the queue, and its first beat is then loaded
// into the output register that drives out_valid_o.
// Throughput: one item per cycle while the queue is not full; the output register
// issues one beat per cycle while out_stall_i is low, and an entry with two
// results stays at the queue head for both beats. The input side keeps accepting
// while beats wait, until the QueueDepth-entry queue fills; then in_stall_o rises.
// Reset clears the retired counter, returns to idle and empties the queue.
// While out_stall_i is high the current beat holds.
`timescale 1ns / 1ps

module x86_control_flow_resolver #(
  parameter int QueueDepth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  xcfr_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output xcfr_pkg::out_item_t out_item_o
);

  logic                push, pop;
  xcfr_pkg::q_entry_t  entry, head;
  xcfr_pkg::q_status_t q_status;

  assign in_stall_o = q_status.full;

  xcfr_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_item_i  (in_item_i),
    .q_full_i   (q_status.full),
    .push_o     (push),
    .entry_o    (entry)
  );

  xcfr_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .entry_i  (entry),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (q_status)
  );

  xcfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .empty_i     (q_status.empty),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

endmodule

### rtl/core/xcfr_front.sv
// Front part: accepts items, decodes the instruction, updates the counter and
// pending-instruction state, and pushes one or two results as a queue entry.
// Depends on xcfr_pkg.
`timescale 1ns / 1ps

module xcfr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  xcfr_pkg::in_item_t  in_item_i,
  input  logic                q_full_i,
  output logic                push_o,
  output xcfr_pkg::q_entry_t  entry_o
);

  logic [63:0]      cnt_q, cnt_d;
  xcfr_pkg::phase_e phase_q, phase_d;
  logic [31:0]      held_pc_q, held_sp_q;
  logic [47:0]      held_bytes_q;
  logic             accept, new_inst;

  function automatic logic [31:0] sext8(logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic cond_true(logic [3:0] cc, logic [11:0] fl);
    logic r;
    case (cc[3:1])
      3'd0:    r = fl[11];
      3'd1:    r = fl[0];
      3'd2:    r = fl[6];
      3'd3:    r = fl[0] | fl[6];
      3'd4:    r = fl[7];
      3'd5:    r = fl[2];
      3'd6:    r = fl[7] ^ fl[11];
      default: r = fl[6] | (fl[7] ^ fl[11]);
    endcase
    return cc[0] ? !r : r;
  endfunction

  function automatic xcfr_pkg::out_item_t done_res(logic [31:0] npc, logic [31:0] nsp);
    xcfr_pkg::out_item_t r;
    r         = '0;
    r.kind    = xcfr_pkg::KIND_DONE;
    r.next_pc = npc;
    r.next_sp = nsp;
    r.last    = 1'b1;
    return r;
  endfunction

  function automatic xcfr_pkg::out_item_t memwr_res(logic [31:0] addr, logic [31:0] val);
    xcfr_pkg::out_item_t r;
    r            = '0;
    r.kind       = xcfr_pkg::KIND_MEM_WR;
    r.address    = addr;
    r.data_value = val;
    return r;
  endfunction

  function automatic xcfr_pkg::out_item_t memreq_res(logic [31:0] addr);
    xcfr_pkg::out_item_t r;
    r         = '0;
    r.kind    = xcfr_pkg::KIND_MEM_REQ;
    r.address = addr;
    r.last    = 1'b1;
    return r;
  endfunction

  function automatic xcfr_pkg::out_item_t regreq_res(logic [2:0] idx);
    xcfr_pkg::out_item_t r;
    r           = '0;
    r.kind      = xcfr_pkg::KIND_REG_REQ;
    r.reg_index = idx;
    r.last      = 1'b1;
    return r;
  endfunction

  function automatic xcfr_pkg::q_entry_t fin_indirect(logic [31:0] target, logic [31:0] hpc,
                                                      logic [7:0] m, logic [31:0] hsp);
    xcfr_pkg::q_entry_t e;
    logic [2:0]         len;
    e = '0;
    case (m[7:6])
      2'd0:    len = (m[2:0] == xcfr_pkg::RM_DISP32) ? 3'd6 : 3'd2;
      2'd1:    len = 3'd3;
      2'd2:    len = 3'd6;
      default: len = 3'd2;
    endcase
    if (m[5:3] == xcfr_pkg::GRP5_CALL) begin
      e.two       = 1'b1;
      e.res_first = memwr_res(hsp - 32'd4, hpc + {29'd0, len});
      e.res_last  = done_res(target, hsp - 32'd4);
    end else begin
      e.res_last = done_res(target, hsp);
    end
    return e;
  endfunction

  logic [7:0]  b0, b1, hb0, hb1;
  logic [31:0] pc, sp, data, w1, w2, disp;
  logic [2:0]  grp_op;
  xcfr_pkg::out_item_t nh, mk;

  assign accept   = in_valid_i && !q_full_i;
  assign new_inst = accept && (in_item_i.req_type == xcfr_pkg::REQ_NEW);
  assign b0       = in_item_i.inst_bytes[7:0];
  assign b1       = in_item_i.inst_bytes[15:8];
  assign w1       = in_item_i.inst_bytes[39:8];
  assign w2       = in_item_i.inst_bytes[47:16];
  assign pc       = in_item_i.pc;
  assign sp       = in_item_i.stack_ptr;
  assign data     = in_item_i.data_word;
  assign hb0      = held_bytes_q[7:0];
  assign hb1      = held_bytes_q[15:8];
  assign grp_op   = b1[5:3];

  always_comb begin
    nh      = '0;
    nh.kind = xcfr_pkg::KIND_NH;
    nh.last = 1'b1;
    mk      = '0;
    disp    = '0;
    entry_o = '0;
    push_o  = 1'b0;
    cnt_d   = cnt_q;
    phase_d = phase_q;
    if (accept) begin
      case (in_item_i.req_type)
        xcfr_pkg::REQ_ADD: begin
          cnt_d = cnt_q + {32'd0, data};
        end
        xcfr_pkg::REQ_NEW: begin
          push_o           = 1'b1;
          phase_d          = xcfr_pkg::PH_IDLE;
          entry_o.res_last = nh;
          if (b0 inside {[8'h70:8'h7F]}) begin
            entry_o.res_last = done_res(pc + 32'd2 +
                (cond_true(b0[3:0], in_item_i.flags) ? sext8(b1) : 32'd0), sp);
          end else begin
            case (b0)
              xcfr_pkg::OP_JMP_SHORT: entry_o.res_last = done_res(pc + 32'd2 + sext8(b1), sp);
              xcfr_pkg::OP_JMP_NEAR:  entry_o.res_last = done_res(pc + 32'd5 + w1, sp);
              xcfr_pkg::OP_CALL: begin
                entry_o.two       = 1'b1;
                entry_o.res_first = memwr_res(sp - 32'd4, pc + 32'd5);
                entry_o.res_last  = done_res(pc + 32'd5 + w1, sp - 32'd4);
              end
              xcfr_pkg::OP_TWO_BYTE: begin
                if (b1 inside {[8'h80:8'h8F]}) begin
                  entry_o.res_last = done_res(pc + 32'd6 +
                      (cond_true(b1[3:0], in_item_i.flags) ? w2 : 32'd0), sp);
                end else if (b1 == xcfr_pkg::OP_RDTSC) begin
                  entry_o.res_last            = done_res(pc + 32'd2, sp);
                  entry_o.res_last.write_mask = 2'd3;
                  entry_o.res_last.eax_value  = cnt_q[31:0];
                  entry_o.res_last.edx_value  = cnt_q[63:32];
                end
              end
              xcfr_pkg::OP_IN_RST: begin
                cnt_d            = '0;
                entry_o.res_last = done_res(pc + 32'd2, sp);
              end
              xcfr_pkg::OP_IN_RD: begin
                cnt_d                       = '0;
                entry_o.res_last            = done_res(pc + 32'd2, sp);
                entry_o.res_last.write_mask = 2'd1;
                entry_o.res_last.eax_value  = cnt_q[31:0];
              end
              xcfr_pkg::OP_OUT_B, xcfr_pkg::OP_OUT_D: begin
                phase_d          = xcfr_pkg::PH_WREG;
                entry_o.res_last = regreq_res(xcfr_pkg::REG_EAX);
              end
              xcfr_pkg::OP_REPZ: begin
                if (b1 == xcfr_pkg::OP_RET) begin
                  phase_d          = xcfr_pkg::PH_WMEM;
                  entry_o.res_last = memreq_res(sp);
                end
              end
              xcfr_pkg::OP_RET: begin
                phase_d          = xcfr_pkg::PH_WMEM;
                entry_o.res_last = memreq_res(sp);
              end
              xcfr_pkg::OP_GRP5: begin
                if ((grp_op == xcfr_pkg::GRP5_CALL || grp_op == xcfr_pkg::GRP5_JMP) &&
                    b1[2:0] != xcfr_pkg::RM_SIB) begin
                  if (b1[7:6] == 2'd0 && b1[2:0] == xcfr_pkg::RM_DISP32) begin
                    phase_d          = xcfr_pkg::PH_WMEM;
                    entry_o.res_last = memreq_res(w2);
                  end else begin
                    phase_d          = xcfr_pkg::PH_WREG;
                    entry_o.res_last = regreq_res(b1[2:0]);
                  end
                end
              end
              default: entry_o.res_last = nh;
            endcase
          end
        end
        xcfr_pkg::REQ_REG: begin
          if (phase_q == xcfr_pkg::PH_WREG) begin
            push_o  = 1'b1;
            phase_d = xcfr_pkg::PH_IDLE;
            if (hb0 == xcfr_pkg::OP_OUT_B || hb0 == xcfr_pkg::OP_OUT_D) begin
              mk.kind           = xcfr_pkg::KIND_MARKER;
              mk.data_value     = (hb0 == xcfr_pkg::OP_OUT_B) ? {24'd0, data[7:0]} : data;
              mk.marker_port    = hb1;
              mk.marker_count   = cnt_q[31:0];
              entry_o.two       = 1'b1;
              entry_o.res_first = mk;
              entry_o.res_last  = done_res(held_pc_q + 32'd2, held_sp_q);
            end else if (hb1[7:6] == 2'd3) begin
              entry_o = fin_indirect(data, held_pc_q, hb1, held_sp_q);
            end else begin
              if (hb1[7:6] == 2'd1) begin
                disp = sext8(held_bytes_q[23:16]);
              end else if (hb1[7:6] == 2'd2) begin
                disp = held_bytes_q[47:16];
              end
              phase_d          = xcfr_pkg::PH_WMEM;
              entry_o.res_last = memreq_res(data + disp);
            end
          end
        end
        default: begin
          if (phase_q == xcfr_pkg::PH_WMEM) begin
            push_o  = 1'b1;
            phase_d = xcfr_pkg::PH_IDLE;
            if (hb0 == xcfr_pkg::OP_GRP5) begin
              entry_o = fin_indirect(data, held_pc_q, hb1, held_sp_q);
            end else begin
              entry_o.res_last = done_res(data, held_sp_q + 32'd4);
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      phase_q <= xcfr_pkg::PH_IDLE;
    end else begin
      cnt_q   <= cnt_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (new_inst) begin
      held_pc_q    <= pc;
      held_bytes_q <= in_item_i.inst_bytes;
      held_sp_q    <= sp;
    end
  end

endmodule

### rtl/core/xcfr_queue.sv
// Short queue of decoded result entries between front and back.
// Depends on xcfr_pkg.
`timescale 1ns / 1ps

module xcfr_queue #(
  parameter int Depth = 2
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  xcfr_pkg::q_entry_t  entry_i,
  input  logic                pop_i,
  output xcfr_pkg::q_entry_t  head_o,
  output xcfr_pkg::q_status_t status_o
);

  localparam int PtrW = $clog2(Depth);
  localparam int CntW = $clog2(Depth + 1);

  xcfr_pkg::q_entry_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]    count_q;
  logic               do_push, do_pop;

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign do_push        = push_i && !status_o.full;
  assign do_pop         = pop_i && !status_o.empty;
  assign head_o         = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

### rtl/core/xcfr_back.sv
// Back part: issues the one or two results of each queue entry, one beat at a
// time, through the output register. Depends on xcfr_pkg.
`timescale 1ns / 1ps

module xcfr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  xcfr_pkg::q_entry_t  head_i,
  input  logic                empty_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output xcfr_pkg::out_item_t out_item_o
);

  logic                out_valid_q, idx_q, load, first_beat;
  xcfr_pkg::out_item_t out_q;

  assign load        = !empty_i && (!out_valid_q || !out_stall_i);
  assign first_beat  = head_i.two && !idx_q;
  assign pop_o       = load && !first_beat;
  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
      idx_q       <= first_beat;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= first_beat ? head_i.res_first : head_i.res_last;
    end
  end

endmodule

### rtl/core/xcfr_checker.sv
// Port-level checker for the x86 control-flow resolver, bound to the top level.
// Depends on xcfr_pkg.
`timescale 1ns / 1ps

module xcfr_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input xcfr_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input xcfr_pkg::out_item_t out_item_o
);

  logic leading_kind;
  assign leading_kind = (out_item_o.kind == xcfr_pkg::KIND_MEM_WR) ||
                        (out_item_o.kind == xcfr_pkg::KIND_MARKER);

  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_item_i))
    else $error("stalled input beat changed");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_item_o))
    else $error("stalled output beat changed");

  a_leading_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && leading_kind |-> !out_item_o.last)
    else $error("write or marker beat flagged last");

  a_other_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_item_o.last |-> leading_kind)
    else $error("non-last beat of wrong kind");

  a_reset_clean: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o && !in_stall_o)
    else $error("output valid or input stalled right after reset");

endmodule

bind x86_control_flow_resolver xcfr_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_item_i   (in_item_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_item_o  (out_item_o)
);

### test/testbench.sv
// Self-checking testbench for x86_control_flow_resolver: directed and random
// instruction, operand-reply and counter beats checked against a local predictor.
// Depends on xcfr_pkg and the x86_control_flow_resolver RTL.
`timescale 1ns / 1ps

module testbench;
  import xcfr_pkg::*;

  localparam logic [3:0] JCC_SHORT_HI = 4'h7;
  localparam logic [3:0] JCC_NEAR_HI  = 4'h8;
  localparam logic [1:0] MOD_MEM      = 2'd0;
  localparam logic [1:0] MOD_DISP8    = 2'd1;
  localparam logic [1:0] MOD_DISP32   = 2'd2;
  localparam logic [1:0] MOD_REG      = 2'd3;
  localparam logic [1:0] WR_NONE      = 2'b00;
  localparam logic [1:0] WR_EAX       = 2'b01;
  localparam logic [1:0] WR_EDX_EAX   = 2'b11;
  localparam int         RANDOM_ITEMS = 1850;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_stall_o;
  in_item_t  in_item_i = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_item_o;

  x86_control_flow_resolver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  logic [63:0] insn_count = '0;
  phase_e      wait_state = PH_IDLE;
  logic [31:0] saved_pc = '0;
  logic [47:0] saved_bytes = '0;
  logic [31:0] saved_sp = '0;
  out_item_t   fresh [2];
  int          fresh_n;
  out_item_t   pending_beats [$];
  int          useful_items = 0;
  int          fault_count = 0;
  int          beat_index = 0;
  bit          calm = 1'b0;
  int          stall_left = 0;
  int          stall_roll;

  function automatic logic [31:0] sext8(logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

  function automatic logic [31:0] word_of(logic [47:0] b, int i);
    return b[8*i +: 32];
  endfunction

  function automatic logic cond_holds(logic [3:0] cc, logic [11:0] fl);
    logic cf, pf, zf, sf, of, r;
    cf = fl[0];
    pf = fl[2];
    zf = fl[6];
    sf = fl[7];
    of = fl[11];
    case (cc[3:1])
      3'd0: r = of;
      3'd1: r = cf;
      3'd2: r = zf;
      3'd3: r = cf | zf;
      3'd4: r = sf;
      3'd5: r = pf;
      3'd6: r = sf ^ of;
      default: r = zf | (sf ^ of);
    endcase
    return r ^ cc[0];
  endfunction

  task automatic emit_beat(input out_item_t b);
    fresh[fresh_n] = b;
    fresh_n++;
  endtask

  task automatic emit_done(input logic [31:0] npc, input logic [31:0] nsp,
                           input logic [1:0] mask, input logic [31:0] eax,
                           input logic [31:0] edx);
    out_item_t b;
    b = '0;
    b.kind = KIND_DONE;
    b.next_pc = npc;
    b.next_sp = nsp;
    b.write_mask = mask;
    b.eax_value = eax;
    b.edx_value = edx;
    emit_beat(b);
  endtask

  task automatic emit_write(input logic [31:0] addr, input logic [31:0] val);
    out_item_t b;
    b = '0;
    b.kind = KIND_MEM_WR;
    b.address = addr;
    b.data_value = val;
    emit_beat(b);
  endtask

  task automatic emit_mem_req(input logic [31:0] addr);
    out_item_t b;
    b = '0;
    b.kind = KIND_MEM_REQ;
    b.address = addr;
    wait_state = PH_WMEM;
    emit_beat(b);
  endtask

  task automatic emit_reg_req(input logic [2:0] r);
    out_item_t b;
    b = '0;
    b.kind = KIND_REG_REQ;
    b.reg_index = r;
    wait_state = PH_WREG;
    emit_beat(b);
  endtask

  task automatic emit_not_handled();
    out_item_t b;
    b = '0;
    b.kind = KIND_NH;
    emit_beat(b);
  endtask

  task automatic finish_indirect(input logic [31:0] target);
    logic [7:0]  m;
    logic [31:0] len;
    m = saved_bytes[15:8];
    case (m[7:6])
      MOD_MEM:    len = (m[2:0] == RM_DISP32) ? 32'd6 : 32'd2;
      MOD_DISP8:  len = 32'd3;
      MOD_DISP32: len = 32'd6;
      default:    len = 32'd2;
    endcase
    if (m[5:3] == GRP5_CALL) begin
      emit_write(saved_sp - 32'd4, saved_pc + len);
      emit_done(target, saved_sp - 32'd4, WR_NONE, '0, '0);
    end else begin
      emit_done(target, saved_sp, WR_NONE, '0, '0);
    end
  endtask

  task automatic decode_insn(input in_item_t it);
    logic [7:0]  b0, b1;
    logic [31:0] pc, sp;
    logic [47:0] bytes;
    bytes = it.inst_bytes;
    b0 = bytes[7:0];
    b1 = bytes[15:8];
    pc = it.pc;
    sp = it.stack_ptr;
    if (b0[7:4] == JCC_SHORT_HI) begin
      emit_done(pc + 32'd2 + (cond_holds(b0[3:0], it.flags) ? sext8(b1) : 32'd0), sp,
                WR_NONE, '0, '0);
    end else begin
      case (b0)
        OP_JMP_SHORT: emit_done(pc + 32'd2 + sext8(b1), sp, WR_NONE, '0, '0);
        OP_JMP_NEAR:  emit_done(pc + 32'd5 + word_of(bytes, 1), sp, WR_NONE, '0, '0);
        OP_CALL: begin
          emit_write(sp - 32'd4, pc + 32'd5);
          emit_done(pc + 32'd5 + word_of(bytes, 1), sp - 32'd4, WR_NONE, '0, '0);
        end
        OP_TWO_BYTE: begin
          if (b1[7:4] == JCC_NEAR_HI) begin
            emit_done(pc + 32'd6 + (cond_holds(b1[3:0], it.flags) ? word_of(bytes, 2) : 32'd0),
                      sp, WR_NONE, '0, '0);
          end else if (b1 == OP_RDTSC) begin
            emit_done(pc + 32'd2, sp, WR_EDX_EAX, insn_count[31:0], insn_count[63:32]);
          end else begin
            emit_not_handled();
          end
        end
        OP_IN_RST: begin
          insn_count = '0;
          emit_done(pc + 32'd2, sp, WR_NONE, '0, '0);
        end
        OP_IN_RD: begin
          emit_done(pc + 32'd2, sp, WR_EAX, insn_count[31:0], '0);
          insn_count = '0;
        end
        OP_OUT_B, OP_OUT_D: emit_reg_req(REG_EAX);
        OP_REPZ: begin
          if (b1 == OP_RET) emit_mem_req(sp);
          else emit_not_handled();
        end
        OP_RET: emit_mem_req(sp);
        OP_GRP5: begin
          if ((b1[5:3] != GRP5_CALL && b1[5:3] != GRP5_JMP) || b1[2:0] == RM_SIB) begin
            emit_not_handled();
          end else if (b1[7:6] == MOD_MEM && b1[2:0] == RM_DISP32) begin
            emit_mem_req(word_of(bytes, 2));
          end else begin
            emit_reg_req(b1[2:0]);
          end
        end
        default: emit_not_handled();
      endcase
    end
  endtask

  task automatic take_register(input logic [31:0] data);
    out_item_t   b;
    logic [7:0]  b0;
    logic [31:0] disp;
    b0 = saved_bytes[7:0];
    if (b0 == OP_OUT_B || b0 == OP_OUT_D) begin
      b = '0;
      b.kind = KIND_MARKER;
      b.data_value = (b0 == OP_OUT_B) ? {24'd0, data[7:0]} : data;
      b.marker_port = saved_bytes[15:8];
      b.marker_count = insn_count[31:0];
      emit_beat(b);
      emit_done(saved_pc + 32'd2, saved_sp, WR_NONE, '0, '0);
    end else if (saved_bytes[15:14] == MOD_REG) begin
      finish_indirect(data);
    end else begin
      case (saved_bytes[15:14])
        MOD_DISP8:  disp = sext8(saved_bytes[23:16]);
        MOD_DISP32: disp = word_of(saved_bytes, 2);
        default:    disp = '0;
      endcase
      emit_mem_req(data + disp);
    end
  endtask

  task automatic resolve_item(input in_item_t it);
    out_item_t b;
    logic      ignored;
    ignored = 1'b0;
    fresh_n = 0;
    case (it.req_type)
      REQ_ADD: insn_count = insn_count + it.data_word;
      REQ_NEW: begin
        wait_state = PH_IDLE;
        saved_pc = it.pc;
        saved_bytes = it.inst_bytes;
        saved_sp = it.stack_ptr;
        decode_insn(it);
      end
      REQ_REG: begin
        if (wait_state == PH_WREG) begin
          wait_state = PH_IDLE;
          take_register(it.data_word);
        end else begin
          ignored = 1'b1;
        end
      end
      default: begin
        if (wait_state == PH_WMEM) begin
          wait_state = PH_IDLE;
          if (saved_bytes[7:0] == OP_GRP5) finish_indirect(it.data_word);
          else emit_done(it.data_word, saved_sp + 32'd4, WR_NONE, '0, '0);
        end else begin
          ignored = 1'b1;
        end
      end
    endcase
    if (!ignored) useful_items++;
    for (int i = 0; i < fresh_n; i++) begin
      b = fresh[i];
      b.last = (i == fresh_n - 1);
      pending_beats.push_back(b);
    end
  endtask

  function automatic int idle_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_beat(input in_item_t it);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    resolve_item(it);
  endtask

  function automatic in_item_t random_item(req_e t);
    in_item_t    it;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    it.req_type = t;
    it.pc = $urandom;
    it.inst_bytes = raw[47:0];
    it.flags = raw[59:48];
    it.stack_ptr = $urandom;
    it.data_word = $urandom;
    return it;
  endfunction

  function automatic in_item_t make_insn(logic [31:0] pc, logic [47:0] bytes,
                                         logic [11:0] fl, logic [31:0] sp);
    in_item_t it;
    it = random_item(REQ_NEW);
    it.pc = pc;
    it.inst_bytes = bytes;
    it.flags = fl;
    it.stack_ptr = sp;
    return it;
  endfunction

  task automatic send_reply(input req_e t, input logic [31:0] data);
    in_item_t it;
    it = random_item(t);
    it.data_word = data;
    send_beat(it);
  endtask

  function automatic logic [47:0] random_insn_bytes();
    logic [63:0] raw;
    logic [7:0]  b0, b1;
    logic [2:0]  op;
    raw = {$urandom, $urandom};
    b0 = raw[7:0];
    b1 = raw[15:8];
    case ($urandom_range(0, 11))
      0: b0 = {JCC_SHORT_HI, raw[3:0]};
      1: begin
        b0 = OP_TWO_BYTE;
        b1 = {JCC_NEAR_HI, raw[11:8]};
      end
      2: b0 = OP_JMP_SHORT;
      3: b0 = OP_JMP_NEAR;
      4: b0 = OP_CALL;
      5: b0 = OP_RET;
      6: begin
        b0 = OP_REPZ;
        if ($urandom_range(0, 4) != 0) b1 = OP_RET;
      end
      7: begin
        b0 = OP_GRP5;
        op = ($urandom_range(0, 4) == 0) ? raw[13:11] :
             ($urandom_range(0, 1) ? GRP5_CALL : GRP5_JMP);
        b1 = {raw[15:14], op, raw[10:8]};
        if ($urandom_range(0, 5) == 0) b1 = {MOD_MEM, op, RM_DISP32};
      end
      8: begin
        b0 = OP_TWO_BYTE;
        b1 = OP_RDTSC;
      end
      9: b0 = raw[16] ? OP_IN_RD : OP_IN_RST;
      10: b0 = raw[16] ? OP_OUT_D : OP_OUT_B;
      default: ;
    endcase
    return {raw[47:16], b1, b0};
  endfunction

  task automatic test_branches();
    send_beat(make_insn(32'h0000_1000, {32'h0, 8'h80, 8'h74}, 12'h040, 32'h0000_8000));
    send_beat(make_insn(32'h0000_2000, {32'h0, 8'h7F, 8'h75}, 12'h040, 32'h0000_8000));
    send_beat(make_insn(32'hFFFF_FFF0, {32'hFFFF_FFFF, 8'h8F, OP_TWO_BYTE}, 12'h000,
                        32'hFFFF_FFFF));
    send_beat(make_insn(32'hFFFF_FFFF, {32'h0, 8'h7F, OP_JMP_SHORT}, 12'hFFF, 32'h0));
    send_beat(make_insn(32'h0, {8'h00, 32'h8000_0000, OP_JMP_NEAR}, 12'hFFF, 32'hFFFF_FFFF));
  endtask

  task automatic test_call_return();
    send_beat(make_insn(32'h0040_0000, {8'hAA, 32'h1234_5678, OP_CALL}, 12'h0, 32'h0));
    send_beat(make_insn(32'h0040_0010, {40'h0, OP_RET}, 12'h0, 32'hFFFF_FFFC));
    send_reply(REQ_MEM, 32'hFFFF_FFFF);
    send_beat(make_insn(32'h0040_0020, {32'h0, OP_RET, OP_REPZ}, 12'h0, 32'h0000_1000));
    send_reply(REQ_MEM, 32'h0);
    send_beat(make_insn(32'h0040_0030, {32'h0, 8'h90, OP_REPZ}, 12'h0, 32'h0000_1000));
  endtask

  task automatic test_indirect();
    send_beat(make_insn(32'hFFFF_FFFC, {32'hDEAD_BEEC, 8'h15, OP_GRP5}, 12'h0, 32'h4));
    send_reply(REQ_MEM, 32'h0040_0000);
    send_beat(make_insn(32'h0000_3000, {32'h0, 8'hE0, OP_GRP5}, 12'h0, 32'h0000_2000));
    send_reply(REQ_REG, 32'hFFFF_FFFF);
    send_beat(make_insn(32'h0000_3100, {24'h0, 8'h80, 8'h50, OP_GRP5}, 12'h0, 32'h0000_2000));
    send_reply(REQ_REG, 32'h0000_0040);
    send_reply(REQ_MEM, 32'h0000_1234);
    send_beat(make_insn(32'h0000_3200, {32'h8000_0000, 8'hA6, OP_GRP5}, 12'h0, 32'h0000_2000));
    send_reply(REQ_REG, 32'h8000_0000);
    send_reply(REQ_MEM, 32'h0000_5678);
    send_beat(make_insn(32'h0000_3300, {32'h0, 8'h14, OP_GRP5}, 12'h0, 32'h0000_2000));
    send_beat(make_insn(32'h0000_3400, {32'h0, 8'h08, OP_GRP5}, 12'h0, 32'h0000_2000));
  endtask

  task automatic test_counter_markers();
    send_reply(REQ_ADD, 32'hFFFF_FFFF);
    send_reply(REQ_ADD, 32'hFFFF_FFFF);
    send_beat(make_insn(32'h0000_4000, {32'h0, OP_RDTSC, OP_TWO_BYTE}, 12'h0, 32'h100));
    send_beat(make_insn(32'h0000_4010, {32'h0, 8'h80, OP_OUT_D}, 12'h0, 32'h100));
    send_reply(REQ_REG, 32'hFFFF_FFFF);
    send_beat(make_insn(32'h0000_4020, {32'h0, 8'hFF, OP_OUT_B}, 12'h0, 32'h100));
    send_reply(REQ_REG, 32'h1234_56AB);
    send_beat(make_insn(32'h0000_4030, {32'h0, 8'h00, OP_IN_RD}, 12'h0, 32'h100));
    send_reply(REQ_ADD, 32'h0000_0007);
    send_beat(make_insn(32'h0000_4040, {32'h0, 8'h00, OP_IN_RST}, 12'h0, 32'h100));
    send_beat(make_insn(32'h0000_4050, {32'h0, OP_RDTSC, OP_TWO_BYTE}, 12'h0, 32'h100));
  endtask

  task automatic test_stray_responses();
    send_reply(REQ_REG, 32'h1111_1111);
    send_reply(REQ_MEM, 32'h2222_2222);
    send_beat(make_insn(32'h0000_5000, {40'h0, OP_RET}, 12'h0, 32'h0000_0800));
    send_reply(REQ_REG, 32'h3333_3333);
    send_beat(make_insn(32'h0000_5010, {32'h0, 8'h10, OP_JMP_SHORT}, 12'h0, 32'h0000_0800));
    send_reply(REQ_MEM, 32'h4444_4444);
    send_beat(make_insn(32'h0000_5020, 48'h0, 12'h0, 32'h0000_0800));
  endtask

  task automatic run_instruction_flow();
    in_item_t it;
    int       r;
    bit       abandon;
    it = random_item(REQ_NEW);
    it.inst_bytes = random_insn_bytes();
    send_beat(it);
    abandon = 1'b0;
    while (wait_state != PH_IDLE && !abandon) begin
      r = $urandom_range(0, 99);
      if (r < 85) send_reply((wait_state == PH_WREG) ? REQ_REG : REQ_MEM, $urandom);
      else if (r < 92) send_beat(random_item(REQ_ADD));
      else if (r < 96) send_reply((wait_state == PH_WREG) ? REQ_MEM : REQ_REG, $urandom);
      else abandon = 1'b1;
    end
  endtask

  task automatic test_random_traffic();
    int target;
    int r;
    target = useful_items + RANDOM_ITEMS;
    while (useful_items < target) begin
      if ($urandom_range(0, 149) == 0) calm = !calm;
      r = $urandom_range(0, 99);
      if (r < 75) run_instruction_flow();
      else if (r < 85) send_beat(random_item(REQ_ADD));
      else send_beat(random_item(req_e'($urandom_range(0, 3))));
    end
    calm = 1'b0;
  endtask

  always @(posedge clk_i) begin : stall_gen
    if (!rst_ni || calm) begin
      out_stall_i <= 1'b0;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 65) begin
        out_stall_i <= 1'b0;
      end else if (stall_roll < 95) begin
        out_stall_i <= 1'b1;
        stall_left <= $urandom_range(0, 2);
      end else begin
        out_stall_i <= 1'b1;
        stall_left <= $urandom_range(8, 30);
      end
    end
  end

  always @(posedge clk_i) begin : beat_check
    out_item_t want;
    string     bad;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_beats.size() == 0) begin
        fault_count++;
        if (fault_count <= 10) $display("beat %0d unexpected: got %h", beat_index, out_item_o);
      end else begin
        want = pending_beats.pop_front();
        bad = "";
        if (out_item_o.kind !== want.kind) bad = {bad, " kind"};
        if (out_item_o.reg_index !== want.reg_index) bad = {bad, " reg_index"};
        if (out_item_o.address !== want.address) bad = {bad, " address"};
        if (out_item_o.data_value !== want.data_value) bad = {bad, " data_value"};
        if (out_item_o.next_pc !== want.next_pc) bad = {bad, " next_pc"};
        if (out_item_o.next_sp !== want.next_sp) bad = {bad, " next_sp"};
        if (out_item_o.write_mask !== want.write_mask) bad = {bad, " write_mask"};
        if (out_item_o.eax_value !== want.eax_value) bad = {bad, " eax_value"};
        if (out_item_o.edx_value !== want.edx_value) bad = {bad, " edx_value"};
        if (out_item_o.marker_port !== want.marker_port) bad = {bad, " marker_port"};
        if (out_item_o.marker_count !== want.marker_count) bad = {bad, " marker_count"};
        if (out_item_o.last !== want.last) bad = {bad, " last"};
        if (bad != "") begin
          fault_count++;
          if (fault_count <= 10) begin
            $display("beat %0d mismatch in%s: expected %h actual %h",
                     beat_index, bad, want, out_item_o);
          end
        end
      end
      beat_index++;
    end
  end

  initial begin
    #8_000_000;
    $display("x86_control_flow_resolver verification failed");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_branches();
    test_call_return();
    test_indirect();
    test_counter_markers();
    test_stray_responses();
    test_random_traffic();
    in_valid_i <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (pending_beats.size() != 0) begin
      fault_count++;
      $display("%0d expected beats never arrived", pending_beats.size());
    end
    if (fault_count == 0) $display("x86_control_flow_resolver verification clean");
    else $display("x86_control_flow_resolver verification failed");
    $finish;
  end

endmodule
